/* rtl/airlock_door_pair_controller_macros.svh */
// assertion macros for the airlock door pair controller checker
`ifndef AIRLOCK_DOOR_PAIR_CONTROLLER_MACROS_SVH
`define AIRLOCK_DOOR_PAIR_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define ADPC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ADPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/adpc_pkg.sv */
// types, constants and the per-door step function of the airlock door pair controller
`default_nettype none

package adpc_pkg;

    localparam int unsigned CNT_W = 16;

    localparam logic [CNT_W-1:0] OPEN_HOLD_RESET     = 16'd5000;
    localparam logic [CNT_W-1:0] BLINK_RESET         = 16'd200;
    localparam logic [CNT_W-1:0] MOTOR_TIMEOUT_RESET = 16'd8000;
    localparam logic [CNT_W-1:0] CNT_MAX             = 16'hFFFF;

    typedef enum logic [2:0] {
        MODE_INIT    = 3'd0,
        MODE_STOP    = 3'd1,
        MODE_OPENING = 3'd2,
        MODE_OPENED  = 3'd3,
        MODE_CLOSING = 3'd4,
        MODE_ERROR   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        CFG_OPEN_HOLD     = 2'd0,
        CFG_BLINK         = 2'd1,
        CFG_MOTOR_TIMEOUT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] hold_ticks;
        logic [CNT_W-1:0] blink_ticks;
        logic [CNT_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic req;
        logic barrier;
        logic closed_sw;
        logic open_sw;
        logic other_closed;
    } door_in_t;

    typedef struct packed {
        mode_t            mode;
        logic             open_drive;
        logic             close_drive;
        logic             lamp;
        logic [CNT_W-1:0] hold_cnt;
        logic [CNT_W-1:0] blink_cnt;
        logic [CNT_W-1:0] tmo_cnt;
    } door_t;

    function automatic door_t door_step(door_t cur, door_in_t din, cfg_t cfg);
        door_t d;
        d = cur;
        if (cur.mode != MODE_OPENED) begin
            d.hold_cnt = '0;
        end
        if (cur.mode != MODE_CLOSING) begin
            d.blink_cnt = '0;
        end
        case (cur.mode)
            MODE_STOP: begin
                d.open_drive  = 1'b0;
                d.close_drive = 1'b0;
                d.lamp        = 1'b0;
                if (din.req && din.other_closed) begin
                    d.mode = MODE_OPENING;
                end
            end
            MODE_OPENING: begin
                d.open_drive  = 1'b1;
                d.close_drive = 1'b0;
                d.lamp        = 1'b0;
                if (din.open_sw) begin
                    d.mode = MODE_OPENED;
                end
            end
            MODE_OPENED: begin
                d.open_drive  = 1'b0;
                d.close_drive = 1'b0;
                d.lamp        = 1'b0;
                d.hold_cnt    = cur.hold_cnt + 16'd1;
                if (d.hold_cnt >= cfg.hold_ticks) begin
                    d.hold_cnt = '0;
                    d.mode     = MODE_CLOSING;
                end
            end
            MODE_CLOSING: begin
                d.open_drive  = 1'b0;
                d.close_drive = 1'b1;
                d.blink_cnt   = cur.blink_cnt + 16'd1;
                if (d.blink_cnt >= cfg.blink_ticks) begin
                    d.blink_cnt = '0;
                    d.lamp      = ~cur.lamp;
                end
                if (din.closed_sw) begin
                    d.mode = MODE_STOP;
                end
                if (din.barrier || din.req) begin
                    d.mode = MODE_OPENING;
                end
            end
            MODE_ERROR: begin
                d.open_drive  = 1'b0;
                d.close_drive = 1'b0;
                d.lamp        = 1'b1;
                if (din.req) begin
                    d.mode = MODE_CLOSING;
                end
            end
            default: begin
                d.lamp = 1'b0;
                d.mode = din.closed_sw ? MODE_STOP : MODE_CLOSING;
            end
        endcase
        // motor watchdog
        if (d.open_drive || d.close_drive) begin
            if (cur.tmo_cnt != CNT_MAX) begin
                d.tmo_cnt = cur.tmo_cnt + 16'd1;
            end
        end else begin
            d.tmo_cnt = '0;
        end
        if (d.tmo_cnt > cfg.timeout_ticks) begin
            d.mode        = MODE_ERROR;
            d.open_drive  = 1'b0;
            d.close_drive = 1'b0;
            d.lamp        = 1'b1;
            d.tmo_cnt     = '0;
            d.hold_cnt    = '0;
            d.blink_cnt   = '0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/airlock_door_pair_controller.sv */
// top level of the airlock door pair controller
// Each input transaction is one scan tick of both doors and yields exactly one output
// transaction holding the drive, lamp and mode of both doors after that tick. A tick is
// captured in an input register and worked out combinationally from there into the result
// register and the door state, and one tick is taken every cycle while the output side
// keeps up. Backpressure on the output stalls both registers in turn. Configuration
// writes apply to ticks evaluated after the write.
`default_nettype none

module airlock_door_pair_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // request_a, request_b, barrier_a, barrier_b,
    // closed_limit_a, open_limit_a, closed_limit_b, open_limit_b
    input  wire logic [7:0]  s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // drive_open_a, drive_close_a, lamp_a, drive_open_b, drive_close_b, lamp_b,
    // mode_a[2:0], mode_b[2:0], four zero bits
    output logic [15:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    adpc_pkg::cfg_t     cfg_reg;
    adpc_pkg::door_t    door_a_reg;
    adpc_pkg::door_t    door_b_reg;
    adpc_pkg::door_t    door_a_next;
    adpc_pkg::door_t    door_b_next;
    adpc_pkg::door_in_t din_a;
    adpc_pkg::door_in_t din_b;

    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [15:0] out_data_next;
    logic        out_free;
    logic        advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        din_a.req          = in_data_reg[0];
        din_a.barrier      = in_data_reg[2];
        din_a.closed_sw    = in_data_reg[4];
        din_a.open_sw      = in_data_reg[5];
        din_a.other_closed = in_data_reg[6];
        din_b.req          = in_data_reg[1];
        din_b.barrier      = in_data_reg[3];
        din_b.closed_sw    = in_data_reg[6];
        din_b.open_sw      = in_data_reg[7];
        din_b.other_closed = in_data_reg[4];
        door_a_next = adpc_pkg::door_step(door_a_reg, din_a, cfg_reg);
        door_b_next = adpc_pkg::door_step(door_b_reg, din_b, cfg_reg);
        out_data_next = {4'b0000, door_b_next.mode, door_a_next.mode,
                         door_b_next.lamp, door_b_next.close_drive, door_b_next.open_drive,
                         door_a_next.lamp, door_a_next.close_drive, door_a_next.open_drive};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_ticks    <= adpc_pkg::OPEN_HOLD_RESET;
            cfg_reg.blink_ticks   <= adpc_pkg::BLINK_RESET;
            cfg_reg.timeout_ticks <= adpc_pkg::MOTOR_TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (adpc_pkg::cfg_idx_t'(cfg_index))
                adpc_pkg::CFG_OPEN_HOLD:     cfg_reg.hold_ticks    <= cfg_wdata;
                adpc_pkg::CFG_BLINK:         cfg_reg.blink_ticks   <= cfg_wdata;
                adpc_pkg::CFG_MOTOR_TIMEOUT: cfg_reg.timeout_ticks <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            door_a_reg    <= '0;
            door_b_reg    <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                door_a_reg <= door_a_next;
                door_b_reg <= door_b_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/adpc_checker.sv */
// port-level assertions for the airlock door pair controller and their bind
`default_nettype none

`include "airlock_door_pair_controller_macros.svh"

module adpc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    logic err_a;
    logic err_b;
    logic drive_ok;
    logic safe_a;
    logic safe_b;
    logic stalled;

    assign err_a    = m_tdata[8:6] == adpc_pkg::MODE_ERROR;
    assign err_b    = m_tdata[11:9] == adpc_pkg::MODE_ERROR;
    assign drive_ok = !(m_tdata[0] && m_tdata[1]) && !(m_tdata[3] && m_tdata[4]);
    assign safe_a   = m_tdata[2] && !m_tdata[0] && !m_tdata[1];
    assign safe_b   = m_tdata[5] && !m_tdata[3] && !m_tdata[4];
    assign stalled  = m_tvalid && !m_tready;

    `ADPC_ASSERT_NOW(a_drive_excl, aclk, aresetn, m_tvalid, drive_ok, "door driven both ways")
    `ADPC_ASSERT_NOW(a_err_a, aclk, aresetn, m_tvalid && err_a, safe_a, "door a error unsafe")
    `ADPC_ASSERT_NOW(a_err_b, aclk, aresetn, m_tvalid && err_b, safe_b, "door b error unsafe")
    `ADPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, stalled, m_tvalid && $stable(m_tdata), "stall")

endmodule

bind airlock_door_pair_controller adpc_checker u_adpc_checker (.*);

`default_nettype wire
